@@ rtl/core/mi3_pkg.sv @@
// Shared constants and types for the 3x3 matrix inverse unit.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;
    localparam int PORT_BITS     = 32;
    localparam int CFG_BITS      = 32;
    localparam int STATUS_BITS   = 2;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEMS         = 9;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        logic ovf;
        logic neg;
    } lane_flags_t;

    // cofactor k = m[p]*m[q] - m[r]*m[s], in adjugate order
    localparam int COF_TERMS [ELEMS][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };
endpackage
`default_nettype wire

@@ rtl/core/matrix_inverse_3x3_unit.sv @@
// Top level of the 3x3 fixed-point matrix inverse unit.
//
//  channel   prefix  handshake          word
//  input     s_      s_valid/s_ready    a00..a22, signed elements
//  result    m_      m_valid/m_ready    r00..r22 and status
//  config    cfg_    cfg_valid/cfg_ready singular_limit
//
// One matrix per cycle while s_ready is high.
// Each lane holds a WORD_BITS+1 stage restoring divider.
// Reset clears valid flags and singular_limit; payload registers are not reset.
// A stalled result drops into a skid register; s_ready falls while it is full.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_unit #(
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a00,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a01,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a02,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a10,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a11,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a12,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a20,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a21,
    input  wire logic [mi3_pkg::PORT_BITS-1:0] s_a22,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r00,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r01,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r02,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r10,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r11,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r12,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r20,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r21,
    output logic [mi3_pkg::PORT_BITS-1:0] m_r22,
    output logic [mi3_pkg::STATUS_BITS-1:0] m_status,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [mi3_pkg::CFG_BITS-1:0] cfg_data
);
    localparam int CW    = 2 * WORD_BITS + 1;
    localparam int DW    = 3 * WORD_BITS + 3;
    localparam int QB    = WORD_BITS + 1;
    localparam int NE    = mi3_pkg::ELEMS;
    localparam int TOTAL = QB + 8;

    logic signed [WORD_BITS-1:0] elem [NE];
    logic signed [CW-1:0]        cof5 [NE];
    logic signed [DW-1:0]        det5;

    logic [mi3_pkg::CFG_BITS-1:0] limit_reg;
    logic                         en;
    logic [TOTAL-1:0]             vld_reg;

    logic signed [CW-1:0] cof6_reg [NE];
    logic [DW-1:0]        mag6_reg;
    logic                 neg6_reg;
    logic                 sing6_reg;
    logic [DW-1:0]        mag5;
    logic                 sing_d_reg [QB+1];

    logic [QB-1:0]                 quo   [NE];
    mi3_pkg::lane_flags_t          flags [NE];
    logic [mi3_pkg::PORT_BITS-1:0] pipe_res [NE];
    mi3_pkg::status_t              pipe_status;
    logic                          pipe_vld;

    logic [mi3_pkg::PORT_BITS-1:0] out_r_reg  [NE];
    logic [mi3_pkg::PORT_BITS-1:0] out_r_next [NE];
    mi3_pkg::status_t              out_st_reg, out_st_next;
    logic                          out_v_reg, out_v_next;
    logic [mi3_pkg::PORT_BITS-1:0] sk_r_reg  [NE];
    logic [mi3_pkg::PORT_BITS-1:0] sk_r_next [NE];
    mi3_pkg::status_t              sk_st_reg, sk_st_next;
    logic                          sk_v_reg, sk_v_next;

    assign elem[0] = $signed(s_a00[WORD_BITS-1:0]);
    assign elem[1] = $signed(s_a01[WORD_BITS-1:0]);
    assign elem[2] = $signed(s_a02[WORD_BITS-1:0]);
    assign elem[3] = $signed(s_a10[WORD_BITS-1:0]);
    assign elem[4] = $signed(s_a11[WORD_BITS-1:0]);
    assign elem[5] = $signed(s_a12[WORD_BITS-1:0]);
    assign elem[6] = $signed(s_a20[WORD_BITS-1:0]);
    assign elem[7] = $signed(s_a21[WORD_BITS-1:0]);
    assign elem[8] = $signed(s_a22[WORD_BITS-1:0]);

    assign en        = ~sk_v_reg;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_valid};
        end
    end

    mi3_cof_det #(.WORD_BITS(WORD_BITS)) u_cof_det (
        .aclk (aclk),
        .en   (en),
        .elem (elem),
        .cof  (cof5),
        .det  (det5)
    );

    assign mag5 = det5[DW-1] ? DW'(-det5) : DW'(det5);

    always_ff @(posedge aclk) begin
        if (en) begin
            cof6_reg  <= cof5;
            mag6_reg  <= mag5;
            neg6_reg  <= det5[DW-1];
            sing6_reg <= mag5 <= DW'(limit_reg);
            sing_d_reg[0] <= sing6_reg;
            for (int i = 1; i <= QB; i++) begin
                sing_d_reg[i] <= sing_d_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_lane
        mi3_div_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk    (aclk),
            .en      (en),
            .cof     (cof6_reg[k]),
            .mag_det (mag6_reg),
            .neg_det (neg6_reg),
            .quo     (quo[k]),
            .flags   (flags[k])
        );
    end

    mi3_merge #(.WORD_BITS(WORD_BITS)) u_merge (
        .aclk   (aclk),
        .en     (en),
        .sing   (sing_d_reg[QB]),
        .quo    (quo),
        .flags  (flags),
        .res    (pipe_res),
        .status (pipe_status)
    );

    assign pipe_vld = vld_reg[TOTAL-1];

    always_comb begin
        out_r_next  = out_r_reg;
        out_st_next = out_st_reg;
        out_v_next  = out_v_reg;
        sk_r_next   = sk_r_reg;
        sk_st_next  = sk_st_reg;
        sk_v_next   = sk_v_reg;
        if (sk_v_reg) begin
            if (m_ready) begin
                out_r_next  = sk_r_reg;
                out_st_next = sk_st_reg;
                out_v_next  = 1'b1;
                sk_v_next   = 1'b0;
            end
        end else if (pipe_vld) begin
            if (!out_v_reg || m_ready) begin
                out_r_next  = pipe_res;
                out_st_next = pipe_status;
                out_v_next  = 1'b1;
            end else begin
                sk_r_next  = pipe_res;
                sk_st_next = pipe_status;
                sk_v_next  = 1'b1;
            end
        end else if (m_ready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_r_reg  <= out_r_next;
        out_st_reg <= out_st_next;
        sk_r_reg   <= sk_r_next;
        sk_st_reg  <= sk_st_next;
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else begin
            out_v_reg <= out_v_next;
            sk_v_reg  <= sk_v_next;
        end
    end

    assign m_valid  = out_v_reg;
    assign m_r00    = out_r_reg[0];
    assign m_r01    = out_r_reg[1];
    assign m_r02    = out_r_reg[2];
    assign m_r10    = out_r_reg[3];
    assign m_r11    = out_r_reg[4];
    assign m_r12    = out_r_reg[5];
    assign m_r20    = out_r_reg[6];
    assign m_r21    = out_r_reg[7];
    assign m_r22    = out_r_reg[8];
    assign m_status = out_st_reg;
endmodule
`default_nettype wire

@@ rtl/core/mi3_cof_det.sv @@
// Cofactor and determinant front end, five pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module mi3_cof_det #(
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
    localparam int CW = 2 * WORD_BITS + 1,
    localparam int DW = 3 * WORD_BITS + 3
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [WORD_BITS-1:0] elem [mi3_pkg::ELEMS],
    output logic signed [CW-1:0]       cof [mi3_pkg::ELEMS],
    output logic signed [DW-1:0]       det
);
    localparam int PW  = 2 * WORD_BITS;
    localparam int PLW = 2 * WORD_BITS + 1;
    localparam int PPW = 3 * WORD_BITS + 1;

    logic signed [PW-1:0]        prod_reg [2*mi3_pkg::ELEMS];
    logic signed [WORD_BITS-1:0] e1_reg [3];
    logic signed [WORD_BITS-1:0] e2_reg [3];
    logic signed [CW-1:0]        cof2_reg [mi3_pkg::ELEMS];
    logic signed [CW-1:0]        cof3_reg [mi3_pkg::ELEMS];
    logic signed [CW-1:0]        cof4_reg [mi3_pkg::ELEMS];
    logic signed [CW-1:0]        cof5_reg [mi3_pkg::ELEMS];
    logic signed [PLW-1:0]       pl_reg [3];
    logic signed [PLW-1:0]       ph_reg [3];
    logic signed [PPW-1:0]       p3_reg [3];
    logic signed [DW-1:0]        det_reg;

    for (genvar k = 0; k < mi3_pkg::ELEMS; k++) begin : g_cof
        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[2*k]   <= elem[mi3_pkg::COF_TERMS[k][0]] *
                                   elem[mi3_pkg::COF_TERMS[k][1]];
                prod_reg[2*k+1] <= elem[mi3_pkg::COF_TERMS[k][2]] *
                                   elem[mi3_pkg::COF_TERMS[k][3]];
                cof2_reg[k]     <= CW'(prod_reg[2*k]) - CW'(prod_reg[2*k+1]);
                cof3_reg[k]     <= cof2_reg[k];
                cof4_reg[k]     <= cof3_reg[k];
                cof5_reg[k]     <= cof4_reg[k];
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        logic signed [WORD_BITS:0] lo;
        logic signed [WORD_BITS:0] hi;
        assign lo = $signed({1'b0, cof2_reg[3*j][WORD_BITS-1:0]});
        assign hi = $signed(cof2_reg[3*j][CW-1:WORD_BITS]);
        always_ff @(posedge aclk) begin
            if (en) begin
                e1_reg[j] <= elem[j];
                e2_reg[j] <= e1_reg[j];
                pl_reg[j] <= e2_reg[j] * lo;
                ph_reg[j] <= e2_reg[j] * hi;
                p3_reg[j] <= (PPW'(ph_reg[j]) <<< WORD_BITS) + PPW'(pl_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= DW'(p3_reg[0]) + DW'(p3_reg[1]) + DW'(p3_reg[2]);
        end
    end

    assign cof = cof5_reg;
    assign det = det_reg;
endmodule
`default_nettype wire

@@ rtl/core/mi3_div_lane.sv @@
// One divider lane: rounded quotient of a cofactor by the determinant.
`timescale 1ns / 1ps
`default_nettype none
module mi3_div_lane #(
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
    localparam int CW = 2 * WORD_BITS + 1,
    localparam int DW = 3 * WORD_BITS + 3,
    localparam int QB = WORD_BITS + 1
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [CW-1:0] cof,
    input  wire logic [DW-1:0]        mag_det,
    input  wire logic                 neg_det,
    output logic [QB-1:0]             quo,
    output mi3_pkg::lane_flags_t      flags
);
    localparam int SH = 2 * FRAC_BITS + 1;
    localparam int NA = CW + SH;
    localparam int NW = ((NA > DW) ? NA : DW) + 1;
    localparam int RW = DW + 1;

    logic [CW-1:0] acof;
    logic [NW-1:0] num;
    logic [RW-1:0] dvs;
    logic [NW-1:0] top_part;
    logic          init_ovf;

    logic [RW-1:0]        r_reg  [QB];
    logic [QB-1:0]        nl_reg [QB];
    logic [RW-1:0]        d_reg  [QB];
    logic [QB-1:0]        q_reg  [QB+1];
    mi3_pkg::lane_flags_t fl_reg [QB+1];

    assign acof     = cof[CW-1] ? CW'(-cof) : CW'(cof);
    assign num      = (NW'(acof) << SH) + NW'(mag_det);
    assign dvs      = {mag_det, 1'b0};
    assign top_part = num >> QB;
    assign init_ovf = top_part >= NW'(dvs);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= RW'(top_part);
            nl_reg[0] <= num[QB-1:0];
            d_reg[0]  <= dvs;
            q_reg[0]  <= '0;
            fl_reg[0] <= '{ovf: init_ovf, neg: cof[CW-1] ^ neg_det};
        end
    end

    for (genvar i = 0; i < QB; i++) begin : g_step
        logic [RW:0] t;
        logic [RW:0] diff;
        logic        ge;
        assign t    = {r_reg[i], nl_reg[i][QB-1]};
        assign diff = t - {1'b0, d_reg[i]};
        assign ge   = t >= {1'b0, d_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i+1]  <= {q_reg[i][QB-2:0], ge};
                fl_reg[i+1] <= fl_reg[i];
            end
        end
        if (i < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[i+1]  <= ge ? diff[RW-1:0] : t[RW-1:0];
                    nl_reg[i+1] <= {nl_reg[i][QB-2:0], 1'b0};
                    d_reg[i+1]  <= d_reg[i];
                end
            end
        end
    end

    assign quo   = q_reg[QB];
    assign flags = fl_reg[QB];
endmodule
`default_nettype wire

@@ rtl/core/mi3_merge.sv @@
// Merge stage: sign, saturation and status over the nine lanes.
`timescale 1ns / 1ps
`default_nettype none
module mi3_merge #(
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
    localparam int QB = WORD_BITS + 1
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic                 sing,
    input  wire logic [QB-1:0]        quo [mi3_pkg::ELEMS],
    input  wire mi3_pkg::lane_flags_t flags [mi3_pkg::ELEMS],
    output logic [mi3_pkg::PORT_BITS-1:0] res [mi3_pkg::ELEMS],
    output mi3_pkg::status_t          status
);
    localparam logic [QB-1:0] POS_MAX = {2'b00, {(WORD_BITS-1){1'b1}}};
    localparam logic [QB-1:0] NEG_MAG = {2'b01, {(WORD_BITS-1){1'b0}}};

    logic [mi3_pkg::PORT_BITS-1:0] res_next [mi3_pkg::ELEMS];
    logic [mi3_pkg::PORT_BITS-1:0] res_reg  [mi3_pkg::ELEMS];
    logic [mi3_pkg::ELEMS-1:0]     sat;
    mi3_pkg::status_t              status_next;
    mi3_pkg::status_t              status_reg;

    always_comb begin
        logic [QB-1:0] mag;
        logic [QB-1:0] val;
        for (int k = 0; k < mi3_pkg::ELEMS; k++) begin
            sat[k] = flags[k].ovf |
                     (flags[k].neg ? (quo[k] > NEG_MAG) : (quo[k] > POS_MAX));
            mag = sat[k] ? (flags[k].neg ? NEG_MAG : POS_MAX) : quo[k];
            val = flags[k].neg ? QB'(-mag) : mag;
            res_next[k] = sing ? '0 : mi3_pkg::PORT_BITS'(val[WORD_BITS-1:0]);
        end
        if (sing) begin
            status_next = mi3_pkg::ST_SINGULAR;
        end else if (|sat) begin
            status_next = mi3_pkg::ST_SAT;
        end else begin
            status_next = mi3_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg    <= res_next;
            status_reg <= status_next;
        end
    end

    assign res    = res_reg;
    assign status = status_reg;
endmodule
`default_nettype wire

@@ rtl/core/mi3_checker.sv @@
// Port-level checks for the matrix inverse unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mi3_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [mi3_pkg::PORT_BITS-1:0] m_r00,
    input wire logic [mi3_pkg::PORT_BITS-1:0] m_r11,
    input wire logic [mi3_pkg::PORT_BITS-1:0] m_r22,
    input wire logic [mi3_pkg::STATUS_BITS-1:0] m_status
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r00) && $stable(m_status))
        else $error("result word changed while stalled");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == mi3_pkg::ST_SINGULAR |->
            m_r00 == '0 && m_r11 == '0 && m_r22 == '0)
        else $error("singular word carries nonzero elements");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
endmodule

bind matrix_inverse_3x3_unit mi3_checker u_mi3_checker (.*);
`default_nettype wire
